>>> src/command_frame_crc5_encoder_assert.svh
// ----------------------------------------------------------------------------
// command frame encoder assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_CRC5_ENCODER_ASSERT_SVH
`define COMMAND_FRAME_CRC5_ENCODER_ASSERT_SVH

// same-cycle implication
`define CFCE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CFCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/cfce_pkg.sv
// ----------------------------------------------------------------------------
// cfce_pkg
// types, opcode constants and the crc5 byte update for the frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package cfce_pkg;

	typedef enum logic [2:0] {
		OP_READ       = 3'd0,
		OP_WRITE      = 3'd1,
		OP_BCAST      = 3'd2,
		OP_PROBE      = 3'd3,
		OP_CHIP_ID    = 3'd4,
		OP_INACTIVATE = 3'd5,
		OP_ADDR_SET   = 3'd6
	} op_t;

	localparam logic [7:0] OPC_READ       = 8'h42;
	localparam logic [7:0] OPC_WRITE      = 8'h41;
	localparam logic [7:0] OPC_BCAST      = 8'h51;
	localparam logic [7:0] OPC_QUERY      = 8'h52;
	localparam logic [7:0] OPC_INACTIVATE = 8'h53;
	localparam logic [7:0] OPC_ADDR_SET   = 8'h40;

	localparam logic [7:0] SHORT_LEN = 8'd5;
	localparam logic [7:0] WRITE_LEN = 8'd9;
	localparam logic [7:0] PROBE_REG = 8'd4;

	localparam logic [4:0] CRC_INIT = 5'h1f;
	localparam logic [4:0] CRC_POLY = 5'h05;

	localparam int FIFO_DEPTH = 2;

	// one decoded command as it sits in the queue
	typedef struct packed {
		logic        is_err;
		logic        is_write;
		logic [7:0]  opcode;
		logic [7:0]  addr;
		logic [7:0]  reg_id;
		logic [31:0] value;
	} cmd_t;

	// msb-first crc5 over one byte
	function automatic logic [4:0] crc5_byte(input logic [4:0] crc_in, input logic [7:0] data);
		logic [4:0] c;
		logic       fb;
		c = crc_in;
		for (int b = 7; b >= 0; b--) begin
			fb = c[4] ^ data[b];
			c  = {c[3:0], 1'b0} ^ (fb ? CRC_POLY : 5'h00);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/cfce_front.sv
// ----------------------------------------------------------------------------
// cfce_front
// decodes a command request into a queue entry, checks room, drops opcode 7
// ----------------------------------------------------------------------------
`default_nettype none

module cfce_front (
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [55:0]         s_tdata,
	output logic                     push,
	output cfce_pkg::cmd_t           cmd
);

	logic [2:0]  op;
	logic [7:0]  target_addr;
	logic [7:0]  target_reg;
	logic [31:0] value;
	logic [3:0]  room;
	logic        known;
	logic [7:0]  frame_len;

	assign op          = s_tdata[2:0];
	assign target_addr = s_tdata[10:3];
	assign target_reg  = s_tdata[18:11];
	assign value       = s_tdata[50:19];
	assign room        = s_tdata[54:51];

	always_comb begin
		known        = 1'b1;
		cmd.is_write = 1'b0;
		cmd.opcode   = cfce_pkg::OPC_READ;
		cmd.addr     = target_addr;
		cmd.reg_id   = target_reg;
		cmd.value    = value;
		unique case (cfce_pkg::op_t'(op))
			cfce_pkg::OP_READ: begin
				cmd.opcode = cfce_pkg::OPC_READ;
			end
			cfce_pkg::OP_WRITE: begin
				cmd.opcode   = cfce_pkg::OPC_WRITE;
				cmd.is_write = 1'b1;
			end
			cfce_pkg::OP_BCAST: begin
				cmd.opcode   = cfce_pkg::OPC_BCAST;
				cmd.addr     = 8'd0;
				cmd.is_write = 1'b1;
			end
			cfce_pkg::OP_PROBE: begin
				cmd.opcode = cfce_pkg::OPC_QUERY;
				cmd.addr   = 8'd0;
				cmd.reg_id = cfce_pkg::PROBE_REG;
			end
			cfce_pkg::OP_CHIP_ID: begin
				cmd.opcode = cfce_pkg::OPC_QUERY;
				cmd.addr   = 8'd0;
				cmd.reg_id = 8'd0;
			end
			cfce_pkg::OP_INACTIVATE: begin
				cmd.opcode = cfce_pkg::OPC_INACTIVATE;
				cmd.addr   = 8'd0;
				cmd.reg_id = 8'd0;
			end
			cfce_pkg::OP_ADDR_SET: begin
				cmd.opcode = cfce_pkg::OPC_ADDR_SET;
				cmd.reg_id = 8'd0;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		frame_len  = cmd.is_write ? cfce_pkg::WRITE_LEN : cfce_pkg::SHORT_LEN;
		cmd.is_err = {4'd0, room} < frame_len;
	end

	// undefined opcode is taken but never queued
	assign push = s_tvalid && s_tready && known;

endmodule

`default_nettype wire

>>> src/cfce_fifo.sv
// ----------------------------------------------------------------------------
// cfce_fifo
// short command queue between the decoder and the serializer
// ----------------------------------------------------------------------------
`default_nettype none

module cfce_fifo #(
	parameter int DEPTH = cfce_pkg::FIFO_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  cfce_pkg::cmd_t      wr_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output cfce_pkg::cmd_t      head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cfce_pkg::cmd_t  entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/cfce_back.sv
// ----------------------------------------------------------------------------
// cfce_back
// serializes the head command one byte per cycle while the output is not stalled, folding in the crc5
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_crc5_encoder_assert.svh"

module cfce_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  cfce_pkg::cmd_t      head,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);

	logic [3:0] idx_q;
	logic [4:0] crc_q;
	logic       m_tvalid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       user_q;

	logic       adv;
	logic       emit;
	logic [3:0] last_idx;
	logic       is_last;
	logic [7:0] byte_val;

	assign adv      = !m_tvalid_q || m_tready;
	assign emit     = adv && head_valid;
	assign last_idx = head.is_write ? 4'd8 : 4'd4;
	assign is_last  = head.is_err || (idx_q == last_idx);
	assign pop      = emit && is_last;

	always_comb begin
		case (idx_q)
			4'd0:    byte_val = head.opcode;
			4'd1:    byte_val = head.is_write ? cfce_pkg::WRITE_LEN : cfce_pkg::SHORT_LEN;
			4'd2:    byte_val = head.addr;
			4'd3:    byte_val = head.reg_id;
			4'd4:    byte_val = head.value[31:24];
			4'd5:    byte_val = head.value[23:16];
			4'd6:    byte_val = head.value[15:8];
			4'd7:    byte_val = head.value[7:0];
			default: byte_val = 8'd0;
		endcase
		if (idx_q == last_idx) begin
			byte_val = {3'd0, crc_q};
		end
		if (head.is_err) begin
			byte_val = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			crc_q      <= cfce_pkg::CRC_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= head_valid;
			end
			if (emit) begin
				if (is_last) begin
					idx_q <= '0;
					crc_q <= cfce_pkg::CRC_INIT;
				end else begin
					idx_q <= idx_q + 1'b1;
					crc_q <= cfce_pkg::crc5_byte(crc_q, byte_val);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= byte_val;
			last_q <= is_last;
			user_q <= head.is_err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

	// byte counter never runs past the crc byte of the head frame
	`CFCE_ASSERT_IMPL(a_idx_in_frame, head_valid && !head.is_err, idx_q <= last_idx)
	// a frame end rewinds the serializer for the next command
	`CFCE_ASSERT_NEXT(a_rewind, pop, idx_q == 4'd0 && crc_q == cfce_pkg::CRC_INIT)
	// an error transaction is a lone zero byte that closes the frame
	`CFCE_ASSERT_IMPL(a_err_shape, m_tvalid && m_tuser, m_tlast && m_tdata == 8'd0)

endmodule

`default_nettype wire

>>> src/command_frame_crc5_encoder.sv
// ----------------------------------------------------------------------------
// command_frame_crc5_encoder
// turns command requests into serial frames with a crc5 trailer byte
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                      tlast      tuser
//   s_axis    in    op, target_addr, target_reg, value, room     -          -
//   m_axis    out   frame_byte                                   last       status
//
// a short command takes 5 output transactions, a write 9, an error 1;
// the serializer emits one byte per cycle while the output is not stalled
// a request is taken whenever the command queue has room, also while bytes
// of earlier frames are stalled at the output register
// reset clears the queue, the byte counter and the output valid
// op 7 is taken and produces nothing
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_crc5_encoder #(
	parameter int FIFO_DEPTH = cfce_pkg::FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] op, [10:3] target_addr, [18:11] target_reg,
	// [50:19] value, [54:51] room, [55] zero
	input  wire logic [55:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] frame_byte
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast,
	// [0] status
	output logic             m_axis_tuser
);

	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;
	cfce_pkg::cmd_t wr_cmd;
	cfce_pkg::cmd_t head;

	// request is accepted while the queue has a free slot
	assign s_axis_tready = !full;

	// decode and room check
	cfce_front u_front (
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.push     (push),
		.cmd      (wr_cmd)
	);

	// decoupling queue
	cfce_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (wr_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// byte serializer with crc and output register
	cfce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.m_tuser    (m_axis_tuser)
	);

endmodule

`default_nettype wire

>>> sim/command_frame_crc5_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_crc5_encoder_tb
// drives command requests into the frame encoder and checks every frame byte
// against a local frame builder with its own crc5, through several phases of
// sender idling and receiver stalls
// ----------------------------------------------------------------------------

module command_frame_crc5_encoder_tb;

	// op 7 has no command behind it, the encoder drops it
	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	// one frame byte as it should leave the master side
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
		logic       status;
	} frame_beat_t;

	// builds the expected frame of each accepted request and checks bytes in order
	class frame_scoreboard;
		frame_beat_t beats_due[$];
		int unsigned error_count;

		function new();
			error_count = 0;
		endfunction

		function int unsigned pending();
			return beats_due.size();
		endfunction

		// crc5 walked msb first over the lowest nbits of prefix
		function logic [4:0] crc5_of_prefix(logic [63:0] prefix, int nbits);
			logic [4:0] crc;
			logic       feedback;
			crc = cfce_pkg::CRC_INIT;
			for (int i = nbits - 1; i >= 0; i--) begin
				feedback = crc[4] ^ prefix[i];
				crc = {crc[3:0], 1'b0} ^ (feedback ? cfce_pkg::CRC_POLY : 5'h00);
			end
			return crc;
		endfunction

		// work out the frame bytes for one accepted request word
		function void note_request(logic [55:0] word);
			logic [2:0]  op;
			logic [7:0]  addr;
			logic [7:0]  reg_id;
			logic [31:0] value;
			logic [3:0]  room;
			logic [7:0]  opcode;
			logic [7:0]  frame_len;
			logic        is_write;
			logic [63:0] prefix;
			logic [7:0]  frame [9];
			frame_beat_t beat;
			op       = word[2:0];
			addr     = word[10:3];
			reg_id   = word[18:11];
			value    = word[50:19];
			room     = word[54:51];
			is_write = 1'b0;
			case (op)
				cfce_pkg::OP_READ: begin
					opcode = cfce_pkg::OPC_READ;
				end
				cfce_pkg::OP_WRITE: begin
					opcode   = cfce_pkg::OPC_WRITE;
					is_write = 1'b1;
				end
				cfce_pkg::OP_BCAST: begin
					opcode   = cfce_pkg::OPC_BCAST;
					addr     = 8'h00;
					is_write = 1'b1;
				end
				cfce_pkg::OP_PROBE: begin
					opcode = cfce_pkg::OPC_QUERY;
					addr   = 8'h00;
					reg_id = cfce_pkg::PROBE_REG;
				end
				cfce_pkg::OP_CHIP_ID: begin
					opcode = cfce_pkg::OPC_QUERY;
					addr   = 8'h00;
					reg_id = 8'h00;
				end
				cfce_pkg::OP_INACTIVATE: begin
					opcode = cfce_pkg::OPC_INACTIVATE;
					addr   = 8'h00;
					reg_id = 8'h00;
				end
				cfce_pkg::OP_ADDR_SET: begin
					opcode = cfce_pkg::OPC_ADDR_SET;
					reg_id = 8'h00;
				end
				default: begin
					return;
				end
			endcase
			frame_len = is_write ? cfce_pkg::WRITE_LEN : cfce_pkg::SHORT_LEN;
			// not enough room: a single error beat instead of the frame
			if ({4'd0, room} < frame_len) begin
				beat.frame_byte = 8'h00;
				beat.last       = 1'b1;
				beat.status     = 1'b1;
				beats_due.push_back(beat);
				return;
			end
			frame[0] = opcode;
			frame[1] = frame_len;
			frame[2] = addr;
			frame[3] = reg_id;
			if (is_write) begin
				{frame[4], frame[5], frame[6], frame[7]} = value;
				prefix = {opcode, frame_len, addr, reg_id, value};
				frame[8] = {3'b000, crc5_of_prefix(prefix, 64)};
			end else begin
				prefix = {32'd0, opcode, frame_len, addr, reg_id};
				frame[4] = {3'b000, crc5_of_prefix(prefix, 32)};
			end
			for (int i = 0; i < frame_len; i++) begin
				beat.frame_byte = frame[i];
				beat.last       = (i == frame_len - 1);
				beat.status     = 1'b0;
				beats_due.push_back(beat);
			end
		endfunction

		// compare one output transaction with the oldest expected beat
		function void check_beat(logic [7:0] frame_byte, logic last, logic status);
			frame_beat_t due;
			if (beats_due.size() == 0) begin
				$error("unexpected frame transaction: frame_byte %0h last %0b status %0b",
					frame_byte, last, status);
				error_count++;
				return;
			end
			due = beats_due.pop_front();
			if (frame_byte !== due.frame_byte) begin
				$error("frame_byte mismatch: expected %0h, got %0h", due.frame_byte, frame_byte);
				error_count++;
			end
			if (last !== due.last) begin
				$error("last mismatch: expected %0b, got %0b", due.last, last);
				error_count++;
			end
			if (status !== due.status) begin
				$error("status mismatch: expected %0b, got %0b", due.status, status);
				error_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [2:0] op, [10:3] target_addr, [18:11] target_reg,
	// [50:19] value, [54:51] room, [55] zero
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] frame_byte
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	// [0] status
	logic        m_axis_tuser;

	// idle and stall odds in percent, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	frame_scoreboard frames = new();

	command_frame_crc5_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver side: random back-pressure at the current stall rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one monitor for both sides so a request is always noted before its bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				frames.note_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				frames.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	// present one request, hold it until taken, then maybe go idle for a while
	task automatic send_request(input logic [2:0] op, input logic [7:0] addr,
		input logic [7:0] reg_id, input logic [31:0] value, input logic [3:0] room);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, room, value, reg_id, addr, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending and wait until every expected frame byte has come out
	task automatic wait_frames_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (frames.pending() != 0)
			@(posedge clk);
	endtask

	// random requests, mostly with enough room; dropped opcodes are not counted
	task automatic run_random_requests(input int unsigned count);
		int unsigned sent;
		logic [2:0]  op;
		int unsigned frame_len;
		logic [3:0]  room;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 4)
				op = OP_UNDEFINED;
			else
				op = 3'($urandom_range(6));
			frame_len = (op == cfce_pkg::OP_WRITE || op == cfce_pkg::OP_BCAST) ? 9 : 5;
			if ($urandom_range(99) < 80)
				room = 4'($urandom_range(15, frame_len));
			else
				room = 4'($urandom_range(15));
			send_request(op, 8'($urandom), 8'($urandom), $urandom, room);
			if (op != OP_UNDEFINED)
				sent++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: every command, field extremes, room at and below each frame length
		send_request(cfce_pkg::OP_READ,       8'h00, 8'h00, 32'h0000_0000, 4'd15);
		send_request(cfce_pkg::OP_READ,       8'hff, 8'hff, 32'hffff_ffff, 4'd5);
		send_request(cfce_pkg::OP_READ,       8'h12, 8'h34, 32'h0000_0000, 4'd4);
		send_request(cfce_pkg::OP_READ,       8'h12, 8'h34, 32'h0000_0000, 4'd0);
		send_request(cfce_pkg::OP_WRITE,      8'hff, 8'hff, 32'hffff_ffff, 4'd9);
		send_request(cfce_pkg::OP_WRITE,      8'h00, 8'h00, 32'h0000_0000, 4'd15);
		send_request(cfce_pkg::OP_WRITE,      8'h01, 8'h02, 32'h1234_5678, 4'd8);
		// broadcast ignores the address, probe and chip id ignore address and register
		send_request(cfce_pkg::OP_BCAST,      8'ha5, 8'h3c, 32'h8000_0001, 4'd9);
		send_request(cfce_pkg::OP_BCAST,      8'ha5, 8'h3c, 32'h8000_0001, 4'd0);
		send_request(cfce_pkg::OP_PROBE,      8'hff, 8'hff, 32'h0000_ffff, 4'd5);
		send_request(cfce_pkg::OP_PROBE,      8'hff, 8'hff, 32'h0000_ffff, 4'd4);
		send_request(cfce_pkg::OP_CHIP_ID,    8'h12, 8'h34, 32'hdead_beef, 4'd15);
		send_request(cfce_pkg::OP_INACTIVATE, 8'hff, 8'hff, 32'hffff_ffff, 4'd7);
		send_request(cfce_pkg::OP_ADDR_SET,   8'h7e, 8'hff, 32'hffff_ffff, 4'd5);
		send_request(cfce_pkg::OP_ADDR_SET,   8'h7e, 8'hff, 32'hffff_ffff, 4'd3);
		// undefined opcode, taken and dropped
		send_request(OP_UNDEFINED,            8'hff, 8'hff, 32'hffff_ffff, 4'd15);
		send_request(OP_UNDEFINED,            8'h00, 8'h00, 32'h0000_0000, 4'd0);
		send_request(cfce_pkg::OP_WRITE,      8'h5a, 8'ha5, 32'ha5a5_a5a5, 4'd10);
		send_request(cfce_pkg::OP_READ,       8'h55, 8'haa, 32'h0000_0000, 4'd15);
		send_request(cfce_pkg::OP_INACTIVATE, 8'h00, 8'h00, 32'h0000_0000, 4'd1);
		send_request(cfce_pkg::OP_CHIP_ID,    8'h00, 8'h00, 32'h0000_0000, 4'd4);
		send_request(cfce_pkg::OP_BCAST,      8'hff, 8'h00, 32'h5a5a_5a5a, 4'd15);

		// sender holds off until the queue is fully emptied
		wait_frames_drained();

		// random phases: free flow, idle sender, stalling receiver, both a little
		run_random_requests(105);
		send_idle_pct = 78;
		run_random_requests(105);
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		run_random_requests(105);
		send_idle_pct  = 15;
		recv_stall_pct = 15;
		run_random_requests(105);

		wait_frames_drained();
		// keep watching the output to catch stray transactions
		repeat (40) @(posedge clk);

		if (frames.error_count == 0 && frames.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
